>>> rtl/core/pew_pkg.sv
`default_nettype none
package pew_pkg;

  localparam int E_W     = 20;  // linear error, Q3.16
  localparam int Q_W     = 16;  // quaternion part, Q1.14
  localparam int ESQ_W   = 40;  // squared error length
  localparam int QSQ_W   = 32;  // squared quaternion vector length
  localparam int ELEN_W  = 28;  // error length, Q24
  localparam int VLEN_W  = 24;  // quaternion vector length, Q22
  localparam int SPD_W   = 44;  // length times gain
  localparam int ANG_W   = 19;  // rotation angle, Q3.16
  localparam int MAG_W   = 35;  // angle times gain
  localparam int GAIN_W  = 16;
  localparam int SPDC_W  = 19;  // speed / distance registers
  localparam int ORI_W   = 18;
  localparam int TOLSQ_W = 38;
  localparam int CORDIC_N = 24;
  localparam int CXY_W   = 30;
  localparam int CZ_W    = 27;
  localparam int MCAP_W  = 27;  // capped angular magnitude
  localparam int DIV_QW  = 20;  // quotient bits
  localparam int DIV_NW  = 48;  // dividend bits
  localparam int DIV_DW  = 28;  // divisor bits
  localparam int LANES   = 6;
  localparam int V_W     = 20;  // velocity output

  localparam logic [1:0] STAT_RUN     = 2'd0;
  localparam logic [1:0] STAT_CONV    = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;
  localparam logic [1:0] STAT_WAIT    = 2'd3;

  typedef struct packed {
    logic                six_axis;
    logic [GAIN_W-1:0]   lin_gain;
    logic [SPDC_W-1:0]   max_spd;
    logic [SPDC_W-1:0]   min_spd;
    logic [SPDC_W-1:0]   boost;
    logic [SPDC_W-1:0]   pos_tol;
    logic [ORI_W-1:0]    ori_tol;
    logic [GAIN_W-1:0]   ang_gain;
    logic [TOLSQ_W-1:0]  pos_tol_sq;
    logic [TOLSQ_W-1:0]  boost_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [E_W-1:0] ex;
    logic signed [E_W-1:0] ey;
    logic signed [E_W-1:0] ez;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
    logic signed [Q_W-1:0] qz;
    logic                  wneg;
    logic [Q_W-1:0]        absw;
    logic                  meas_ok;
    logic                  timed_out;
    logic [ESQ_W-1:0]      esq;
    logic [QSQ_W-1:0]      qsq;
    logic                  pos_ok;
    logic                  boost_gt;
    logic [ELEN_W-1:0]     elen;
    logic [VLEN_W-1:0]     vlen;
    logic [SPD_W-1:0]      spd;
    logic [ANG_W-1:0]      angle;
    logic [MAG_W-1:0]      mag;
  } item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      scaled;
    logic                      ang_en;
    logic [LANES-1:0]          neg;
    logic [2:0][V_W-1:0]       lin_lo;
  } side_t;

  function automatic logic signed [CZ_W-1:0] atan_q24(input int unsigned i);
    logic signed [CZ_W-1:0] r;
    case (i)
      0:  r = 27'sd13176795;
      1:  r = 27'sd7778716;
      2:  r = 27'sd4110060;
      3:  r = 27'sd2086331;
      4:  r = 27'sd1047214;
      5:  r = 27'sd524117;
      6:  r = 27'sd262123;
      7:  r = 27'sd131069;
      8:  r = 27'sd65536;
      9:  r = 27'sd32768;
      10: r = 27'sd16384;
      11: r = 27'sd8192;
      12: r = 27'sd4096;
      13: r = 27'sd2048;
      14: r = 27'sd1024;
      15: r = 27'sd512;
      16: r = 27'sd256;
      17: r = 27'sd128;
      18: r = 27'sd64;
      19: r = 27'sd32;
      20: r = 27'sd16;
      21: r = 27'sd8;
      22: r = 27'sd4;
      23: r = 27'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // signed saturation of a sign and magnitude to the velocity range
  function automatic logic [V_W-1:0] sat_v(input logic neg, input logic [27:0] mag);
    logic [V_W-1:0] r;
    if (!neg) begin
      r = (mag > 28'd524287) ? 20'h7FFFF : mag[V_W-1:0];
    end else begin
      r = (mag > 28'd524288) ? 20'h80000 : (~mag[V_W-1:0] + 20'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pose_error_twist_regulator.sv
// Stages from input transaction to result: 3 square/sum stages, 28 square-root
// stages, 26 CORDIC stages, 23 decision/divide/output stages.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// result is not taken. Reset (rst_n low, synchronous) empties the pipeline and
// loads the register defaults.
`default_nettype none
module pose_error_twist_regulator #(
  parameter int unsigned MAX_ANGULAR_SPEED = 32768
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // err_x, err_y, err_z, rot_x, rot_y, rot_z, rot_w, zero pad
  input  logic [127:0] in_tdata,
  // measurement_ok, timed_out
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // lin_vx, lin_vy, lin_vz, ang_vx, ang_vy, ang_vz
  output logic [119:0] out_tdata,
  // status
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import pew_pkg::*;

  localparam logic [2:0] REG_SIX      = 3'd0;
  localparam logic [2:0] REG_LIN_GAIN = 3'd1;
  localparam logic [2:0] REG_MAX_SPD  = 3'd2;
  localparam logic [2:0] REG_MIN_SPD  = 3'd3;
  localparam logic [2:0] REG_BOOST    = 3'd4;
  localparam logic [2:0] REG_POS_TOL  = 3'd5;
  localparam logic [2:0] REG_ORI_TOL  = 3'd6;
  localparam logic [2:0] REG_ANG_GAIN = 3'd7;

  logic              six_r;
  logic [GAIN_W-1:0] lin_gain_r, ang_gain_r;
  logic [SPDC_W-1:0] max_spd_r, min_spd_r, boost_r, pos_tol_r;
  logic [ORI_W-1:0]  ori_tol_r;
  logic [TOLSQ_W-1:0] pos_tol_sq_r, boost_sq_r;
  logic              wr;
  cfg_t              cfg;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      six_r      <= 1'b1;
      lin_gain_r <= 16'd256;
      max_spd_r  <= 19'd6554;
      min_spd_r  <= '0;
      boost_r    <= '0;
      pos_tol_r  <= 19'd328;
      ori_tol_r  <= 18'd3431;
      ang_gain_r <= 16'd256;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_SIX:      six_r      <= cfg_pwdata[0];
        REG_LIN_GAIN: lin_gain_r <= cfg_pwdata[GAIN_W-1:0];
        REG_MAX_SPD:  max_spd_r  <= cfg_pwdata[SPDC_W-1:0];
        REG_MIN_SPD:  min_spd_r  <= cfg_pwdata[SPDC_W-1:0];
        REG_BOOST:    boost_r    <= cfg_pwdata[SPDC_W-1:0];
        REG_POS_TOL:  pos_tol_r  <= cfg_pwdata[SPDC_W-1:0];
        REG_ORI_TOL:  ori_tol_r  <= cfg_pwdata[ORI_W-1:0];
        REG_ANG_GAIN: ang_gain_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // squared thresholds are registered, following the registers in the next cycle
  always_ff @(posedge clk) begin
    pos_tol_sq_r <= TOLSQ_W'(pos_tol_r) * TOLSQ_W'(pos_tol_r);
    boost_sq_r   <= TOLSQ_W'(boost_r) * TOLSQ_W'(boost_r);
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SIX:      cfg_prdata = 32'(six_r);
      REG_LIN_GAIN: cfg_prdata = 32'(lin_gain_r);
      REG_MAX_SPD:  cfg_prdata = 32'(max_spd_r);
      REG_MIN_SPD:  cfg_prdata = 32'(min_spd_r);
      REG_BOOST:    cfg_prdata = 32'(boost_r);
      REG_POS_TOL:  cfg_prdata = 32'(pos_tol_r);
      REG_ORI_TOL:  cfg_prdata = 32'(ori_tol_r);
      REG_ANG_GAIN: cfg_prdata = 32'(ang_gain_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg            = '0;
    cfg.six_axis   = six_r;
    cfg.lin_gain   = lin_gain_r;
    cfg.max_spd    = max_spd_r;
    cfg.min_spd    = min_spd_r;
    cfg.boost      = boost_r;
    cfg.pos_tol    = pos_tol_r;
    cfg.ori_tol    = ori_tol_r;
    cfg.ang_gain   = ang_gain_r;
    cfg.pos_tol_sq = pos_tol_sq_r;
    cfg.boost_sq   = boost_sq_r;
  end

  // advance everything unless a finished result is held
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  item_t in_item;
  logic  [Q_W-1:0] rw;

  always_comb begin
    rw              = in_tdata[123:108];
    in_item         = '0;
    in_item.ex      = $signed(in_tdata[19:0]);
    in_item.ey      = $signed(in_tdata[39:20]);
    in_item.ez      = $signed(in_tdata[59:40]);
    in_item.qx      = $signed(in_tdata[75:60]);
    in_item.qy      = $signed(in_tdata[91:76]);
    in_item.qz      = $signed(in_tdata[107:92]);
    in_item.wneg    = rw[Q_W-1];
    in_item.absw    = rw[Q_W-1] ? (~rw + 16'd1) : rw;
    in_item.meas_ok = in_tuser[0];
    in_item.timed_out = in_tuser[1];
  end

  logic  f_valid, r_valid, c_valid;
  item_t f_item,  r_item,  c_item;

  pew_front u_front (
    .clk, .rst_n, .en, .cfg,
    .in_valid (in_tvalid), .in_item (in_item),
    .out_valid(f_valid),   .out_item(f_item)
  );

  pew_root u_root (
    .clk, .rst_n, .en,
    .in_valid (f_valid), .in_item (f_item),
    .out_valid(r_valid), .out_item(r_item)
  );

  pew_cordic u_cordic (
    .clk, .rst_n, .en, .cfg,
    .in_valid (r_valid), .in_item (r_item),
    .out_valid(c_valid), .out_item(c_item)
  );

  pew_div #(
    .MAX_ANGULAR_SPEED(MAX_ANGULAR_SPEED)
  ) u_div (
    .clk, .rst_n, .en, .cfg,
    .in_valid  (c_valid),    .in_item (c_item),
    .out_valid (out_tvalid), .out_data(out_tdata),
    .out_status(out_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/core/pew_front.sv
`default_nettype none
module pew_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pew_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  pew_pkg::item_t in_item,
  output logic           out_valid,
  output pew_pkg::item_t out_item
);
  import pew_pkg::*;

  logic             va_r, vb_r, vc_r;
  item_t            ia_r, ib_r, ic_r;
  item_t            ib_nxt, ic_nxt;
  logic [ESQ_W-1:0] esq_r [3];
  logic [QSQ_W-1:0] qsq_r [3];

  // squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia_r     <= in_item;
      esq_r[0] <= ESQ_W'(in_item.ex) * ESQ_W'(in_item.ex);
      esq_r[1] <= ESQ_W'(in_item.ey) * ESQ_W'(in_item.ey);
      esq_r[2] <= ESQ_W'(in_item.ez) * ESQ_W'(in_item.ez);
      qsq_r[0] <= QSQ_W'(in_item.qx) * QSQ_W'(in_item.qx);
      qsq_r[1] <= QSQ_W'(in_item.qy) * QSQ_W'(in_item.qy);
      qsq_r[2] <= QSQ_W'(in_item.qz) * QSQ_W'(in_item.qz);
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_comb begin
    ib_nxt     = ia_r;
    ib_nxt.esq = esq_r[0] + esq_r[1] + esq_r[2];
    ib_nxt.qsq = qsq_r[0] + qsq_r[1] + qsq_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ib_r <= ib_nxt;
    end
  end

  // tolerance compares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_comb begin
    ic_nxt          = ib_r;
    ic_nxt.pos_ok   = (ib_r.esq <= ESQ_W'(cfg.pos_tol_sq));
    ic_nxt.boost_gt = (ib_r.esq > ESQ_W'(cfg.boost_sq));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ic_r <= ic_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_item  = ic_r;

endmodule
`default_nettype wire

>>> rtl/core/pew_root.sv
`default_nettype none
module pew_root (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pew_pkg::item_t in_item,
  output logic           out_valid,
  output pew_pkg::item_t out_item
);
  import pew_pkg::*;

  localparam int N    = ELEN_W;
  localparam int QOFF = ELEN_W - VLEN_W;

  logic              v_r     [N];
  item_t             it_r    [N];
  logic [ELEN_W+1:0] erem_r  [N];
  logic [ELEN_W-1:0] eroot_r [N];
  logic [VLEN_W+1:0] qrem_r  [N];
  logic [VLEN_W-1:0] qroot_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic              v_p;
    item_t             it_p;
    logic [ELEN_W+1:0] erem_p,  erem_n;
    logic [ELEN_W-1:0] eroot_p, eroot_n;
    logic [VLEN_W+1:0] qrem_p,  qrem_n;
    logic [VLEN_W-1:0] qroot_p, qroot_n;
    logic [2*ELEN_W-1:0] erad;
    logic [2*VLEN_W-1:0] qrad;
    logic [ELEN_W+3:0] et, ed;

    if (k == 0) begin : g_first
      assign v_p     = in_valid;
      assign it_p    = in_item;
      assign erem_p  = '0;
      assign eroot_p = '0;
      assign qrem_p  = '0;
      assign qroot_p = '0;
    end else begin : g_next
      assign v_p     = v_r[k-1];
      assign it_p    = it_r[k-1];
      assign erem_p  = erem_r[k-1];
      assign eroot_p = eroot_r[k-1];
      assign qrem_p  = qrem_r[k-1];
      assign qroot_p = qroot_r[k-1];
    end

    assign erad = {it_p.esq, 16'b0};
    assign qrad = {it_p.qsq, 16'b0};

    // one result bit per stage
    always_comb begin
      et = {erem_p, erad[2*ELEN_W-1-2*k -: 2]};
      ed = et - {2'b00, eroot_p, 2'b01};
      if (et >= {2'b00, eroot_p, 2'b01}) begin
        erem_n  = ed[ELEN_W+1:0];
        eroot_n = {eroot_p[ELEN_W-2:0], 1'b1};
      end else begin
        erem_n  = et[ELEN_W+1:0];
        eroot_n = {eroot_p[ELEN_W-2:0], 1'b0};
      end
    end

    if (k >= QOFF) begin : g_q
      logic [VLEN_W+3:0] qt, qd;
      always_comb begin
        qt = {qrem_p, qrad[2*VLEN_W-1-2*(k-QOFF) -: 2]};
        qd = qt - {2'b00, qroot_p, 2'b01};
        if (qt >= {2'b00, qroot_p, 2'b01}) begin
          qrem_n  = qd[VLEN_W+1:0];
          qroot_n = {qroot_p[VLEN_W-2:0], 1'b1};
        end else begin
          qrem_n  = qt[VLEN_W+1:0];
          qroot_n = {qroot_p[VLEN_W-2:0], 1'b0};
        end
      end
    end else begin : g_qidle
      assign qrem_n  = qrem_p;
      assign qroot_n = qroot_p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k]    <= it_p;
        erem_r[k]  <= erem_n;
        eroot_r[k] <= eroot_n;
        qrem_r[k]  <= qrem_n;
        qroot_r[k] <= qroot_n;
      end
    end
  end

  always_comb begin
    out_item      = it_r[N-1];
    out_item.elen = eroot_r[N-1];
    out_item.vlen = qroot_r[N-1];
  end
  assign out_valid = v_r[N-1];

endmodule
`default_nettype wire

>>> rtl/core/pew_cordic.sv
`default_nettype none
module pew_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pew_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  pew_pkg::item_t in_item,
  output logic           out_valid,
  output pew_pkg::item_t out_item
);
  import pew_pkg::*;

  logic                   v0_r;
  item_t                  it0_r, it0_nxt;
  logic signed [CXY_W-1:0] x0_r, y0_r;

  logic                   v_r  [CORDIC_N];
  item_t                  it_r [CORDIC_N];
  logic signed [CXY_W-1:0] x_r [CORDIC_N];
  logic signed [CXY_W-1:0] y_r [CORDIC_N];
  logic signed [CZ_W-1:0]  z_r [CORDIC_N];

  logic       va_r;
  item_t      ita_r, ita_nxt;
  logic [CZ_W-1:0] zpos, zsum;
  logic [ANG_W-1:0] angle_n;

  // load vector and form length times gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_comb begin
    it0_nxt     = in_item;
    it0_nxt.spd = SPD_W'(in_item.elen) * SPD_W'(cfg.lin_gain);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r <= it0_nxt;
      x0_r  <= CXY_W'({in_item.absw, 8'b0});
      y0_r  <= CXY_W'(in_item.vlen);
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_it
    logic                    v_p;
    item_t                   it_p;
    logic signed [CXY_W-1:0] xp, yp, xn, yn;
    logic signed [CZ_W-1:0]  zp, zn;

    if (i == 0) begin : g_first
      assign v_p  = v0_r;
      assign it_p = it0_r;
      assign xp   = x0_r;
      assign yp   = y0_r;
      assign zp   = '0;
    end else begin : g_next
      assign v_p  = v_r[i-1];
      assign it_p = it_r[i-1];
      assign xp   = x_r[i-1];
      assign yp   = y_r[i-1];
      assign zp   = z_r[i-1];
    end

    // rotate toward the x axis
    always_comb begin
      if (yp > 0) begin
        xn = xp + (yp >>> i);
        yn = yp - (xp >>> i);
        zn = zp + atan_q24(i);
      end else begin
        xn = xp - (yp >>> i);
        yn = yp + (xp >>> i);
        zn = zp - atan_q24(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i] <= it_p;
        x_r[i]  <= xn;
        y_r[i]  <= yn;
        z_r[i]  <= zn;
      end
    end
  end

  // half angle to full angle in Q3.16, then times gain
  always_comb begin
    zpos = (z_r[CORDIC_N-1] < 0) ? '0 : $unsigned(z_r[CORDIC_N-1]);
    zsum = zpos + CZ_W'(64);
    angle_n = (it_r[CORDIC_N-1].qsq == '0) ? '0 : zsum[ANG_W+6:7];
    ita_nxt       = it_r[CORDIC_N-1];
    ita_nxt.angle = angle_n;
    ita_nxt.mag   = MAG_W'(angle_n) * MAG_W'(cfg.ang_gain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_r[CORDIC_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ita_r <= ita_nxt;
    end
  end

  assign out_valid = va_r;
  assign out_item  = ita_r;

endmodule
`default_nettype wire

>>> rtl/core/pew_div.sv
`default_nettype none
module pew_div #(
  parameter int unsigned MAX_ANGULAR_SPEED = 32768
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pew_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  pew_pkg::item_t in_item,
  output logic           out_valid,
  output logic [119:0]   out_data,
  output logic [1:0]     out_status
);
  import pew_pkg::*;

  localparam logic [MCAP_W-1:0] CAP = MCAP_W'(MAX_ANGULAR_SPEED) << 8;

  // decision stage
  logic              vd_r;
  item_t             itd_r;
  side_t             sd_r, sd_n;
  logic [SPDC_W-1:0] tgt_r, tgt_n;
  logic [MCAP_W-1:0] m_r, m_n;

  logic              ang_ok, boost_hit;
  logic signed [E_W-1:0] ev [3];
  logic signed [36:0] lprod [3];
  logic [35:0]        lmag  [3];
  logic [35:0]        lrnd  [3];

  always_comb begin
    ev[0] = in_item.ex;
    ev[1] = in_item.ey;
    ev[2] = in_item.ez;
    sd_n  = '0;
    tgt_n = '0;
    m_n   = (in_item.mag > MAG_W'(CAP)) ? CAP : in_item.mag[MCAP_W-1:0];
    ang_ok = !cfg.six_axis || (in_item.angle <= ANG_W'(cfg.ori_tol));
    boost_hit = (in_item.spd != '0) && in_item.boost_gt &&
                (in_item.spd < SPD_W'({cfg.min_spd, 16'b0}));
    for (int i = 0; i < 3; i++) begin
      lprod[i] = ev[i] * $signed({1'b0, cfg.lin_gain});
      lmag[i]  = lprod[i][36] ? 36'(-lprod[i]) : lprod[i][35:0];
      lrnd[i]  = lmag[i] + 36'd128;
      sd_n.lin_lo[i] = sat_v(lprod[i][36], lrnd[i][35:8]);
    end
    if (in_item.timed_out) begin
      sd_n.status = STAT_TIMEOUT;
    end else if (!in_item.meas_ok) begin
      sd_n.status = STAT_WAIT;
    end else if (in_item.pos_ok && ang_ok) begin
      sd_n.status = STAT_CONV;
    end else begin
      sd_n.status = STAT_RUN;
    end
    if (in_item.spd > SPD_W'({cfg.max_spd, 16'b0})) begin
      sd_n.scaled = 1'b1;
      tgt_n       = cfg.max_spd;
    end else if (boost_hit) begin
      sd_n.scaled = 1'b1;
      tgt_n       = cfg.min_spd;
    end
    sd_n.ang_en = cfg.six_axis && (in_item.qsq != '0) && (in_item.angle != '0);
    sd_n.neg[0] = in_item.ex[E_W-1];
    sd_n.neg[1] = in_item.ey[E_W-1];
    sd_n.neg[2] = in_item.ez[E_W-1];
    sd_n.neg[3] = in_item.wneg ^ in_item.qx[Q_W-1];
    sd_n.neg[4] = in_item.wneg ^ in_item.qy[Q_W-1];
    sd_n.neg[5] = in_item.wneg ^ in_item.qz[Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itd_r <= in_item;
      sd_r  <= sd_n;
      tgt_r <= tgt_n;
      m_r   <= m_n;
    end
  end

  // dividend and divisor per lane, rounding half folded into the dividend
  logic              vn_r;
  side_t             sn_r;
  logic [DIV_NW-1:0] nn_r [LANES];
  logic [DIV_DW-1:0] dn_r [LANES];

  logic [E_W-1:0]    ae [3];
  logic [Q_W-1:0]    aq [3];
  logic [38:0]       pe [3];
  logic [42:0]       pq [3];
  logic [DIV_NW-1:0] nn_n [LANES];
  logic [DIV_DW-1:0] dn_n [LANES];

  always_comb begin
    ae[0] = itd_r.ex[E_W-1] ? E_W'(-itd_r.ex) : itd_r.ex;
    ae[1] = itd_r.ey[E_W-1] ? E_W'(-itd_r.ey) : itd_r.ey;
    ae[2] = itd_r.ez[E_W-1] ? E_W'(-itd_r.ez) : itd_r.ez;
    aq[0] = itd_r.qx[Q_W-1] ? Q_W'(-itd_r.qx) : itd_r.qx;
    aq[1] = itd_r.qy[Q_W-1] ? Q_W'(-itd_r.qy) : itd_r.qy;
    aq[2] = itd_r.qz[Q_W-1] ? Q_W'(-itd_r.qz) : itd_r.qz;
    for (int i = 0; i < 3; i++) begin
      pe[i] = 39'(ae[i]) * 39'(tgt_r);
      pq[i] = 43'(aq[i]) * 43'(m_r);
      nn_n[i]   = {1'b0, pe[i], 8'b0} + DIV_NW'(itd_r.elen >> 1);
      dn_n[i]   = itd_r.elen;
      nn_n[3+i] = DIV_NW'(pq[i]) + DIV_NW'(itd_r.vlen >> 1);
      dn_n[3+i] = DIV_DW'(itd_r.vlen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (en) begin
      vn_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= sd_r;
      for (int l = 0; l < LANES; l++) begin
        nn_r[l] <= nn_n[l];
        dn_r[l] <= dn_n[l];
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic              v_r   [DIV_QW];
  side_t             s_r   [DIV_QW];
  logic [DIV_NW-1:0] num_r [DIV_QW][LANES];
  logic [DIV_DW-1:0] den_r [DIV_QW][LANES];
  logic [DIV_DW-1:0] rem_r [DIV_QW][LANES];
  logic [DIV_QW-1:0] quo_r [DIV_QW][LANES];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_dv
    logic              v_p;
    side_t             s_p;
    logic [DIV_NW-1:0] num_p [LANES];
    logic [DIV_DW-1:0] den_p [LANES];
    logic [DIV_DW-1:0] rem_p [LANES];
    logic [DIV_QW-1:0] quo_p [LANES];
    logic [DIV_DW-1:0] rem_n [LANES];
    logic [DIV_QW-1:0] quo_n [LANES];
    logic [DIV_DW:0]   t     [LANES];
    logic [DIV_DW:0]   d     [LANES];

    if (k == 0) begin : g_first
      assign v_p = vn_r;
      assign s_p = sn_r;
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign num_p[l] = nn_r[l];
        assign den_p[l] = dn_r[l];
        assign rem_p[l] = nn_r[l][DIV_NW-1:DIV_QW];
        assign quo_p[l] = '0;
      end
    end else begin : g_next
      assign v_p = v_r[k-1];
      assign s_p = s_r[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign num_p[l] = num_r[k-1][l];
        assign den_p[l] = den_r[k-1][l];
        assign rem_p[l] = rem_r[k-1][l];
        assign quo_p[l] = quo_r[k-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l] = {rem_p[l], num_p[l][DIV_QW-1-k]};
        d[l] = t[l] - {1'b0, den_p[l]};
        if (t[l] >= {1'b0, den_p[l]}) begin
          rem_n[l] = d[l][DIV_DW-1:0];
          quo_n[l] = {quo_p[l][DIV_QW-2:0], 1'b1};
        end else begin
          rem_n[l] = t[l][DIV_DW-1:0];
          quo_n[l] = {quo_p[l][DIV_QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_p;
        for (int l = 0; l < LANES; l++) begin
          num_r[k][l] <= num_p[l];
          den_r[k][l] <= den_p[l];
          rem_r[k][l] <= rem_n[l];
          quo_r[k][l] <= quo_n[l];
        end
      end
    end
  end

  // sign, saturate, select
  logic             vo_r;
  logic [119:0]     data_r, data_n;
  logic [1:0]       stat_r;
  side_t            sl;
  logic             run;

  always_comb begin
    sl     = s_r[DIV_QW-1];
    run    = (sl.status == STAT_RUN);
    data_n = '0;
    for (int i = 0; i < 3; i++) begin
      if (run) begin
        data_n[V_W*i +: V_W] = sl.scaled ?
            sat_v(sl.neg[i], 28'(quo_r[DIV_QW-1][i])) : sl.lin_lo[i];
      end
      if (run && sl.ang_en) begin
        data_n[V_W*(3+i) +: V_W] = sat_v(sl.neg[3+i], 28'(quo_r[DIV_QW-1][3+i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[DIV_QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_n;
      stat_r <= sl.status;
    end
  end

  assign out_valid  = vo_r;
  assign out_data   = data_r;
  assign out_status = stat_r;

endmodule
`default_nettype wire

>>> tb/pew_tb_pkg.sv
package pew_tb_pkg;

  typedef enum int {
    REG_SIX_AXIS  = 0,
    REG_LIN_GAIN  = 1,
    REG_MAX_SPEED = 2,
    REG_MIN_SPEED = 3,
    REG_BOOST     = 4,
    REG_POS_TOL   = 5,
    REG_ORI_TOL   = 6,
    REG_ANG_GAIN  = 7
  } reg_idx_e;

  localparam int NUM_REGS = 8;

endpackage

>>> tb/pose_error_twist_checker.sv
module pose_error_twist_checker
  import pew_pkg::*;
  import pew_tb_pkg::*;
#(
  parameter longint unsigned MAX_ANG = 32768
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           twists_pending
);

  longint unsigned six_axis, lin_gain, max_spd, min_spd, boost, pos_tol, ori_tol, ang_gain;
  logic [121:0] twist_q[$];

  longint arctan_q24[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned m, qt;
    m = (num < 0) ? longint'(-num) : num;
    qt = (m + den / 2) / den;
    return (num < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic longint clamp20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // vectoring CORDIC on (|w|, |v|); result is the full angle in Q3.16
  function automatic longint unsigned rotation_angle(longint unsigned absw,
                                                     longint unsigned vlen);
    longint x, y, z, nx, ny;
    x = longint'(absw << 8);
    y = longint'(vlen);
    z = 0;
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + arctan_q24[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - arctan_q24[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    return (longint'(z) + 64) >> 7;
  endfunction

  function automatic logic [121:0] predict_twist(logic [127:0] d, logic [1:0] u);
    longint e[3], q[3], qw, lin[3], ang[3], sg;
    longint unsigned esq, qsq, vlen, angle, elen, spd, target, mag, cap;
    logic [1:0] st;
    bit scaled, pos_ok, ang_ok;
    logic [121:0] r;
    for (int i = 0; i < 3; i++) begin
      e[i] = longint'($signed(d[20*i +: 20]));
      q[i] = longint'($signed(d[60 + 16*i +: 16]));
      lin[i] = 0;
      ang[i] = 0;
    end
    qw = longint'($signed(d[108 +: 16]));
    if (u[1]) begin
      st = STAT_TIMEOUT;
    end else if (!u[0]) begin
      st = STAT_WAIT;
    end else begin
      esq = 0;
      qsq = 0;
      angle = 0;
      for (int i = 0; i < 3; i++) begin
        esq += longint'(e[i] * e[i]);
        qsq += longint'(q[i] * q[i]);
      end
      vlen = root64(qsq << 16);
      if (qsq != 0) angle = rotation_angle((qw < 0) ? -qw : qw, vlen);
      pos_ok = esq <= pos_tol * pos_tol;
      ang_ok = (six_axis == 0) || (angle <= ori_tol);
      if (pos_ok && ang_ok) begin
        st = STAT_CONV;
      end else begin
        st = STAT_RUN;
        elen = root64(esq << 16);
        spd = elen * lin_gain;
        scaled = 0;
        target = 0;
        if (spd > (max_spd << 16)) begin
          target = max_spd;
          scaled = 1;
        end else if (spd > 0 && esq > boost * boost && spd < (min_spd << 16)) begin
          target = min_spd;
          scaled = 1;
        end
        for (int i = 0; i < 3; i++) begin
          if (scaled) lin[i] = round_div(e[i] * 256 * longint'(target), elen);
          else lin[i] = round_div(e[i] * longint'(lin_gain), 256);
          lin[i] = clamp20(lin[i]);
        end
        if (six_axis != 0 && qsq != 0 && angle != 0) begin
          mag = angle * ang_gain;
          cap = MAX_ANG << 8;
          if (mag > cap) mag = cap;
          sg = (qw < 0) ? -1 : 1;
          for (int i = 0; i < 3; i++)
            ang[i] = clamp20(round_div(sg * q[i] * longint'(mag), vlen));
        end
      end
    end
    r[121:120] = st;
    for (int i = 0; i < 3; i++) begin
      r[20*i +: 20] = lin[i][19:0];
      r[60 + 20*i +: 20] = ang[i][19:0];
    end
    return r;
  endfunction

  task automatic report(string field, logic [19:0] got, logic [19:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, field,
             $signed(got), $signed(want));
    fail_count++;
  endtask

  string lane_names[6] = '{"lin_vx", "lin_vy", "lin_vz", "ang_vx", "ang_vy", "ang_vz"};

  initial begin
    fail_count = 0;
    twists_pending = 0;
  end

  always @(posedge clk) begin
    logic [121:0] want;
    if (!rst_n) begin
      six_axis = 1;
      lin_gain = 256;
      max_spd  = 6554;
      min_spd  = 0;
      boost    = 0;
      pos_tol  = 328;
      ori_tol  = 3431;
      ang_gain = 256;
      twist_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        twist_q.push_back(predict_twist(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (twist_q.size() == 0) begin
          $display("[%0t] result transaction with nothing expected", $time);
          fail_count++;
        end else begin
          want = twist_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (out_tdata[20*i +: 20] !== want[20*i +: 20])
              report(lane_names[i], out_tdata[20*i +: 20], want[20*i +: 20]);
          if (out_tuser !== want[121:120])
            report("status", 20'(out_tuser), 20'(want[121:120]));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (int'(cfg_paddr[4:2]))
          REG_SIX_AXIS:  six_axis = cfg_pwdata[0];
          REG_LIN_GAIN:  lin_gain = cfg_pwdata[15:0];
          REG_MAX_SPEED: max_spd  = cfg_pwdata[18:0];
          REG_MIN_SPEED: min_spd  = cfg_pwdata[18:0];
          REG_BOOST:     boost    = cfg_pwdata[18:0];
          REG_POS_TOL:   pos_tol  = cfg_pwdata[18:0];
          REG_ORI_TOL:   ori_tol  = cfg_pwdata[17:0];
          REG_ANG_GAIN:  ang_gain = cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
    twists_pending = twist_q.size();
  end

endmodule

>>> tb/pose_error_twist_regulator_tb.sv
module pose_error_twist_regulator_tb;
  import pew_pkg::*;
  import pew_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN = 120;  // longer than the pipeline depth

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel = 0;
  logic         cfg_penable = 0;
  logic         cfg_pwrite = 0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int fail_count, twists_pending;
  int cycles = 0;
  int hold_off = 0;
  bit send_quiet = 0, take_quiet = 0, no_gaps = 0;
  longint unsigned regs[NUM_REGS];

  pose_error_twist_regulator DUT (.*);

  pose_error_twist_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .twists_pending
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 29) == 0) take_quiet = !take_quiet;
      w = take_quiet ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_tick(logic signed [19:0] ex, ey, ez,
                           logic signed [15:0] qx, qy, qz, qw,
                           bit meas_ok, bit timeout);
    int gap;
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    gap = (send_quiet || no_gaps) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {4'b0, qw, qz, qy, qx, ez, ey, ex};
    in_tuser <= {timeout, meas_ok};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_e idx, longint unsigned val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= 5'(int'(idx) * 4);
    cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(negedge clk);
  endtask

  // idle the input, drain, then load every register
  task automatic load_regs();
    in_tvalid <= 0;
    @(negedge clk);
    while (twists_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    for (int i = 0; i < NUM_REGS; i++) cfg_write(reg_idx_e'(i), regs[i]);
  endtask

  function automatic logic signed [19:0] rand_err();
    int m;
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: m = $urandom_range(0, 400);
      2: m = $urandom_range(0, 4000);
      3: m = $urandom_range(0, 70000);
      4: m = $urandom_range(0, 524287);
      default: begin
        case ($urandom_range(0, 2))
          0: return -20'sd524288;
          1: return 20'sd524287;
          default: return 20'sd0;
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? 20'(-m) : 20'(m);
  endfunction

  function automatic logic signed [15:0] rand_quat(bit vec);
    int v;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    v = $urandom_range(0, 32768) - 16384;
    if (vec) v = v >>> $urandom_range(0, 14);
    return 16'(v);
  endfunction

  task automatic send_random(int n);
    bit ok, to;
    for (int k = 0; k < n; k++) begin
      ok = $urandom_range(0, 9) != 0;
      to = $urandom_range(0, 14) == 0;
      send_tick(rand_err(), rand_err(), rand_err(), rand_quat(1), rand_quat(1),
                rand_quat(1), rand_quat(0), ok, to);
    end
  endtask

  task automatic random_regs();
    regs[REG_SIX_AXIS]  = $urandom_range(0, 3) != 0;
    regs[REG_LIN_GAIN]  = $urandom_range(0, 1) ? $urandom_range(0, 1024) : $urandom_range(0, 65535);
    regs[REG_MAX_SPEED] = $urandom_range(0, 524287);
    regs[REG_MIN_SPEED] = $urandom_range(0, 200000);
    regs[REG_BOOST]     = $urandom_range(0, 100000);
    regs[REG_POS_TOL]   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 524287) : $urandom_range(0, 2000);
    regs[REG_ORI_TOL]   = $urandom_range(0, 205887);
    regs[REG_ANG_GAIN]  = $urandom_range(0, 65535);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed ticks at reset settings
    send_tick(1000, 2000, 3000, 0, 0, 0, 16384, 1, 1);          // timeout
    send_tick(1000, 2000, 3000, 0, 0, 0, 16384, 0, 0);          // unusable measurement
    send_tick(1000, 2000, 3000, 0, 0, 0, 16384, 0, 1);          // both, timeout wins
    send_tick(0, 0, 0, 0, 0, 0, 16384, 1, 0);                   // converged
    send_tick(100, -100, 200, 100, 0, 0, 16384, 1, 0);          // converged, small angle
    send_tick(0, 0, 0, 0, 0, 0, 0, 1, 0);                       // all-zero quaternion
    send_tick(524287, 524287, 524287, 16384, 0, 0, 0, 1, 0);    // far, half turn
    send_tick(-524288, -524288, -524288, 0, -16384, 0, 0, 1, 0);
    send_tick(2000, 0, 0, 1, 0, 0, 16384, 1, 0);                // very small nonzero angle
    send_tick(0, 0, 0, 8000, 5000, -3000, -12000, 1, 0);        // negative w
    send_tick(0, 0, 0, 0, 0, 16384, 0, 1, 0);                   // w zero
    send_tick(0, 0, 0, 11585, 0, 0, 11585, 1, 0);               // quarter turn
    send_tick(500, 0, 0, 0, 0, 0, 16384, 1, 0);                 // linear only, unscaled
    send_tick(0, 0, 0, -32768, 32767, -32768, -32768, 1, 0);    // field extremes
    send_tick(-1, 1, 0, 32767, -32768, 32767, 32767, 1, 0);

    // extremes: position only, full gains, zero position tolerance
    regs = '{0, 65535, 524287, 0, 0, 0, 205887, 65535};
    load_regs();
    send_tick(0, 0, 0, 16384, 0, 0, 0, 1, 0);
    send_tick(1, 0, 0, 16384, 0, 0, 0, 1, 0);
    send_tick(524287, -524288, 1, 100, 200, 300, 400, 1, 0);
    send_random(60);

    // opposite extremes: zero gains and speed cap, largest floor, boost and position tolerance
    regs = '{1, 0, 0, 524287, 524287, 524287, 0, 0};
    load_regs();
    send_tick(524287, 524287, 524287, 16384, 0, 0, 0, 1, 0);    // zero gain, no boost
    send_tick(0, 0, 0, 100, 0, 0, 16384, 1, 0);
    send_random(60);

    // speed floor active beyond boost distance
    regs = '{1, 16, 524287, 200000, 1000, 100, 100, 1000};
    load_regs();
    send_tick(5000, -3000, 2000, 3000, 0, 0, 16000, 1, 0);
    send_tick(500, 0, 0, 0, 0, 0, 16384, 1, 0);                 // inside boost distance
    send_random(60);

    // fill the pipeline: receiver holds off while the sender streams
    regs = '{1, 256, 6554, 0, 0, 328, 3431, 256};
    load_regs();
    no_gaps = 1;
    hold_off = 400;
    send_random(150);
    no_gaps = 0;

    for (int p = 0; p < 5; p++) begin
      random_regs();
      load_regs();
      send_random(80);
    end

    in_tvalid <= 0;
    @(negedge clk);
    while (twists_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
